// ----- sv/r2fft_pkg.sv -----
`timescale 1ns / 1ps
// r2fft_pkg: widths, state codes, control struct and twiddle table of the radix-2 fft engine
// no dependencies

package r2fft_pkg;

    localparam int MAX_POINTS   = 64;
    localparam int ADDR_W       = 6;
    localparam int MAX_LOG2     = 6;
    localparam int SAMPLE_W     = 16;
    localparam int TWID_W       = 16;
    localparam int DATA_W       = 24;
    localparam int ENTRY_W      = 2 * DATA_W;
    localparam int COEF_W       = TWID_W + 1;
    localparam int PROD_W       = DATA_W + COEF_W;
    localparam int PSUM_W       = PROD_W + 1;
    localparam int T_W          = PSUM_W - (TWID_W - 1);
    localparam int BSUM_W       = T_W + 1;

    localparam logic [0:0] REG_INVERSE = 1'b0;
    localparam logic [0:0] REG_LOG2    = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_BF_RA,
        ST_BF_RB,
        ST_BF_MUL,
        ST_BF_TW,
        ST_BF_WA,
        ST_BF_WB,
        ST_SC_RD,
        ST_SC_WR,
        ST_EM_RD,
        ST_EM_LD,
        ST_EM_OUT
    } state_t;

    typedef struct packed {
        logic cap_u;
        logic mul;
        logic twd;
        logic sum_b;
    } bfly_ctrl_t;

    // cos(2*pi*p/64) in q1.15, p = 0..16, +1.0 held at full scale
    function automatic logic [TWID_W-1:0] quarter_cos(input logic [4:0] p);
        logic [TWID_W-1:0] v;
        case (p)
            5'd0:    v = 16'd32767;
            5'd1:    v = 16'd32610;
            5'd2:    v = 16'd32138;
            5'd3:    v = 16'd31357;
            5'd4:    v = 16'd30274;
            5'd5:    v = 16'd28899;
            5'd6:    v = 16'd27246;
            5'd7:    v = 16'd25330;
            5'd8:    v = 16'd23170;
            5'd9:    v = 16'd20788;
            5'd10:   v = 16'd18205;
            5'd11:   v = 16'd15447;
            5'd12:   v = 16'd12540;
            5'd13:   v = 16'd9512;
            5'd14:   v = 16'd6393;
            5'd15:   v = 16'd3212;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [COEF_W-1:0] twiddle_cos(input logic [4:0] p);
        logic signed [COEF_W-1:0] m;
        if (p <= 5'd16) begin
            m = $signed({1'b0, quarter_cos(p)});
        end else begin
            m = -$signed({1'b0, quarter_cos(5'(6'd32 - {1'b0, p}))});
        end
        return m;
    endfunction

    function automatic logic signed [COEF_W-1:0] twiddle_sin(input logic [4:0] p);
        logic signed [COEF_W-1:0] m;
        if (p <= 5'd16) begin
            m = $signed({1'b0, quarter_cos(5'd16 - p)});
        end else begin
            m = $signed({1'b0, quarter_cos(p - 5'd16)});
        end
        return m;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [BSUM_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > $signed(BSUM_W'(2 ** (DATA_W - 1) - 1))) begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (x < -$signed(BSUM_W'(2 ** (DATA_W - 1)))) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/r2fft_ram.sv -----
`timescale 1ns / 1ps
// r2fft_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies

module r2fft_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/r2fft_bfly.sv -----
`timescale 1ns / 1ps
// r2fft_bfly: butterfly datapath, complex multiply with rounding and saturated sum and difference
// depends on r2fft_pkg

module r2fft_bfly (
    input  logic                                  aclk,
    input  r2fft_pkg::bfly_ctrl_t                 ctrl,
    input  logic [r2fft_pkg::ENTRY_W-1:0]         rd_data,
    input  logic signed [r2fft_pkg::COEF_W-1:0]   w_re,
    input  logic signed [r2fft_pkg::COEF_W-1:0]   w_im,
    output logic [r2fft_pkg::ENTRY_W-1:0]         a_data,
    output logic [r2fft_pkg::ENTRY_W-1:0]         b_data
);

    localparam logic signed [r2fft_pkg::PSUM_W-1:0] RND =
        r2fft_pkg::PSUM_W'(2 ** (r2fft_pkg::TWID_W - 2));

    logic signed [r2fft_pkg::DATA_W-1:0] u_re_reg, u_im_reg, v_re, v_im;
    logic signed [r2fft_pkg::PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [r2fft_pkg::T_W-1:0]    t_re_reg, t_im_reg;
    logic signed [r2fft_pkg::PSUM_W-1:0] s_re, s_im;
    logic signed [r2fft_pkg::BSUM_W-1:0] a_re, a_im, b_re, b_im;
    logic [r2fft_pkg::ENTRY_W-1:0]       b_reg;

    function automatic logic signed [r2fft_pkg::PSUM_W-1:0] PSUM_W_ext(
        input logic signed [r2fft_pkg::PROD_W-1:0] x);
        return {x[r2fft_pkg::PROD_W-1], x};
    endfunction

    assign v_re = rd_data[r2fft_pkg::ENTRY_W-1:r2fft_pkg::DATA_W];
    assign v_im = rd_data[r2fft_pkg::DATA_W-1:0];

    // floor shift of the rounded sum is a plain bit select
    assign s_re = PSUM_W_ext(p_rr_reg) - PSUM_W_ext(p_ii_reg) + RND;
    assign s_im = PSUM_W_ext(p_ri_reg) + PSUM_W_ext(p_ir_reg) + RND;

    assign a_re = r2fft_pkg::BSUM_W'(u_re_reg) + r2fft_pkg::BSUM_W'(t_re_reg);
    assign a_im = r2fft_pkg::BSUM_W'(u_im_reg) + r2fft_pkg::BSUM_W'(t_im_reg);
    assign b_re = r2fft_pkg::BSUM_W'(u_re_reg) - r2fft_pkg::BSUM_W'(t_re_reg);
    assign b_im = r2fft_pkg::BSUM_W'(u_im_reg) - r2fft_pkg::BSUM_W'(t_im_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.cap_u) begin
            u_re_reg <= v_re;
            u_im_reg <= v_im;
        end
        if (ctrl.mul) begin
            p_rr_reg <= r2fft_pkg::PROD_W'(v_re * w_re);
            p_ii_reg <= r2fft_pkg::PROD_W'(v_im * w_im);
            p_ri_reg <= r2fft_pkg::PROD_W'(v_re * w_im);
            p_ir_reg <= r2fft_pkg::PROD_W'(v_im * w_re);
        end
        if (ctrl.twd) begin
            t_re_reg <= s_re[r2fft_pkg::PSUM_W-1:r2fft_pkg::TWID_W-1];
            t_im_reg <= s_im[r2fft_pkg::PSUM_W-1:r2fft_pkg::TWID_W-1];
        end
        if (ctrl.sum_b) begin
            b_reg <= {r2fft_pkg::sat_data(b_re), r2fft_pkg::sat_data(b_im)};
        end
    end

    assign a_data = {r2fft_pkg::sat_data(a_re), r2fft_pkg::sat_data(a_im)};
    assign b_data = b_reg;

endmodule

// ----- sv/radix2_fft_engine.sv -----
`timescale 1ns / 1ps
// radix2_fft_engine: top level of the in-place radix-2 dit fft
// depends on r2fft_pkg, r2fft_ram, r2fft_bfly

// usage
// - input channel s_valid/s_ready carries one complex sample per transfer, in natural
//   order; the engine writes it to the sample ram at the bit-reversed address
// - loading accepts one sample per cycle while s_ready is high
// - after the n-th sample s_ready drops; log2(n) stages of n/2 butterflies run out of
//   the single ram, each butterfly stepping through read a, read b, multiply, round,
//   write a and write b
// - inverse mode adds a scaling pass that reads, rounds and writes back each bin
// - bins leave on m_valid/m_ready in natural order, each read from the ram after the
//   previous one is taken, last_bin marks bin n-1; a stalled receiver just holds the
//   output register and the engine waits
// - the engine accepts the next frame once the last bin has been taken
// - config writes (inverse_mode, log2_points) land at once and must only be issued
//   while idle; log2_points above 6 counts as 6
// - reset clears the load count and inverse_mode and sets log2_points to 6; ram contents are left as is

module radix2_fft_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_sample_real,
    input  logic signed [15:0] s_sample_imag,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_bin_real,
    output logic signed [23:0] m_bin_imag,
    output logic [5:0]         m_bin_index,
    output logic               m_last_bin,
    input  logic               cfg_wr_en,
    input  logic [0:0]         cfg_index,
    input  logic [2:0]         cfg_wdata
);

    localparam int AW = r2fft_pkg::ADDR_W;
    localparam int DW = r2fft_pkg::DATA_W;

    r2fft_pkg::state_t state_reg, state_next;

    logic                 inverse_reg;
    logic [2:0]           log2_reg;
    logic [AW:0]          load_count_reg, load_count_next;
    logic [AW-2:0]        bf_reg, bf_next;
    logic [2:0]           stage_reg, stage_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic                 m_valid_reg, m_valid_next;
    logic [r2fft_pkg::ENTRY_W-1:0] out_data_reg;
    logic [AW-1:0]        out_index_reg;
    logic                 out_last_reg;

    // effective size
    logic [2:0]           k_eff;
    logic [AW:0]          n_full;
    logic [AW-1:0]        n_mask;

    // ram ports
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [r2fft_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

    // butterfly addressing and twiddle
    logic [AW-1:0]        half_mask, bf_ext, addr_a, addr_b, j_idx;
    logic [4:0]           tw_p;
    logic signed [r2fft_pkg::COEF_W-1:0] w_re, w_im, w_sin;
    r2fft_pkg::bfly_ctrl_t bctrl;
    logic [r2fft_pkg::ENTRY_W-1:0] a_data, b_data;

    // load path
    logic [AW-1:0]        lc_low, lc_rev, load_addr;
    logic [AW:0]          lc_plus;
    logic signed [DW-1:0] samp_re, samp_im;

    // scaling path
    logic signed [DW:0]   sc_rnd, sc_re, sc_im;
    logic signed [DW-1:0] rd_re, rd_im;

    assign k_eff  = (log2_reg > 3'(r2fft_pkg::MAX_LOG2)) ? 3'(r2fft_pkg::MAX_LOG2) : log2_reg;
    assign n_full = (AW+1)'(1) << k_eff;
    assign n_mask = AW'(n_full - (AW+1)'(1));

    // bit reversal over k bits: reverse all address bits, drop the unused low end
    assign lc_low = load_count_reg[AW-1:0] & n_mask;
    always_comb begin
        for (int i = 0; i < AW; i++) begin
            lc_rev[i] = lc_low[AW-1-i];
        end
    end
    assign load_addr = lc_rev >> (3'(AW) - k_eff);
    assign lc_plus   = load_count_reg + (AW+1)'(1);
    assign samp_re   = DW'(s_sample_real);
    assign samp_im   = DW'(s_sample_imag);

    // a = group spread by one bit with j kept, b = a plus half
    assign half_mask = AW'((AW+1)'(1) << stage_reg) - AW'(1);
    assign bf_ext    = {1'b0, bf_reg};
    assign j_idx     = bf_ext & half_mask;
    assign addr_a    = ((bf_ext & ~half_mask) << 1) | j_idx;
    assign addr_b    = addr_a | (half_mask + AW'(1));
    assign tw_p      = 5'(j_idx << (3'(AW - 1) - stage_reg));
    assign w_re      = r2fft_pkg::twiddle_cos(tw_p);
    assign w_sin     = r2fft_pkg::twiddle_sin(tw_p);
    assign w_im      = inverse_reg ? w_sin : -w_sin;

    // round to nearest on the 1/n scale
    assign rd_re  = ram_rdata[r2fft_pkg::ENTRY_W-1:DW];
    assign rd_im  = ram_rdata[DW-1:0];
    assign sc_rnd = (DW+1)'(1) << (k_eff - 3'd1);
    assign sc_re  = ((DW+1)'(rd_re) + sc_rnd) >>> k_eff;
    assign sc_im  = ((DW+1)'(rd_im) + sc_rnd) >>> k_eff;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inverse_reg <= 1'b0;
            log2_reg    <= 3'd6;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                r2fft_pkg::REG_INVERSE: inverse_reg <= cfg_wdata[0];
                r2fft_pkg::REG_LOG2:    log2_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= r2fft_pkg::ST_LOAD;
            load_count_reg <= '0;
            bf_reg         <= '0;
            stage_reg      <= '0;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            bf_reg         <= bf_next;
            stage_reg      <= stage_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // output register, captured from the ram in the cycle after the read
    always_ff @(posedge aclk) begin
        if (state_reg == r2fft_pkg::ST_EM_LD) begin
            out_data_reg  <= ram_rdata;
            out_index_reg <= idx_reg;
            out_last_reg  <= (idx_reg == n_mask);
        end
    end

    always_comb begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        bf_next         = bf_reg;
        stage_next      = stage_reg;
        idx_next        = idx_reg;
        m_valid_next    = m_valid_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_a;
        ram_wdata       = a_data;
        ram_raddr       = addr_a;
        bctrl           = '0;
        s_ready         = 1'b0;

        case (state_reg)
            r2fft_pkg::ST_LOAD: begin
                s_ready   = 1'b1;
                ram_waddr = load_addr;
                ram_wdata = {samp_re, samp_im};
                if (s_valid) begin
                    ram_we = 1'b1;
                    if (lc_plus >= n_full) begin
                        load_count_next = '0;
                        bf_next         = '0;
                        stage_next      = '0;
                        idx_next        = '0;
                        // a single point needs neither butterflies nor scaling
                        state_next = (k_eff == 3'd0) ? r2fft_pkg::ST_EM_RD
                                                     : r2fft_pkg::ST_BF_RA;
                    end else begin
                        load_count_next = lc_plus;
                    end
                end
            end
            r2fft_pkg::ST_BF_RA: begin
                ram_raddr  = addr_a;
                state_next = r2fft_pkg::ST_BF_RB;
            end
            r2fft_pkg::ST_BF_RB: begin
                ram_raddr   = addr_b;
                bctrl.cap_u = 1'b1;
                state_next  = r2fft_pkg::ST_BF_MUL;
            end
            r2fft_pkg::ST_BF_MUL: begin
                bctrl.mul  = 1'b1;
                state_next = r2fft_pkg::ST_BF_TW;
            end
            r2fft_pkg::ST_BF_TW: begin
                bctrl.twd  = 1'b1;
                state_next = r2fft_pkg::ST_BF_WA;
            end
            r2fft_pkg::ST_BF_WA: begin
                ram_we      = 1'b1;
                ram_waddr   = addr_a;
                ram_wdata   = a_data;
                bctrl.sum_b = 1'b1;
                state_next  = r2fft_pkg::ST_BF_WB;
            end
            r2fft_pkg::ST_BF_WB: begin
                ram_we     = 1'b1;
                ram_waddr  = addr_b;
                ram_wdata  = b_data;
                state_next = r2fft_pkg::ST_BF_RA;
                if ({1'b0, bf_reg} == (n_mask >> 1)) begin
                    bf_next = '0;
                    if (stage_reg == k_eff - 3'd1) begin
                        idx_next   = '0;
                        state_next = inverse_reg ? r2fft_pkg::ST_SC_RD
                                                 : r2fft_pkg::ST_EM_RD;
                    end else begin
                        stage_next = stage_reg + 3'd1;
                    end
                end else begin
                    bf_next = bf_reg + (AW-1)'(1);
                end
            end
            r2fft_pkg::ST_SC_RD: begin
                ram_raddr  = idx_reg;
                state_next = r2fft_pkg::ST_SC_WR;
            end
            r2fft_pkg::ST_SC_WR: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = {sc_re[DW-1:0], sc_im[DW-1:0]};
                if (idx_reg == n_mask) begin
                    idx_next   = '0;
                    state_next = r2fft_pkg::ST_EM_RD;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = r2fft_pkg::ST_SC_RD;
                end
            end
            r2fft_pkg::ST_EM_RD: begin
                ram_raddr  = idx_reg;
                state_next = r2fft_pkg::ST_EM_LD;
            end
            r2fft_pkg::ST_EM_LD: begin
                m_valid_next = 1'b1;
                state_next   = r2fft_pkg::ST_EM_OUT;
            end
            r2fft_pkg::ST_EM_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (idx_reg == n_mask) begin
                        idx_next   = '0;
                        state_next = r2fft_pkg::ST_LOAD;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = r2fft_pkg::ST_EM_RD;
                    end
                end
            end
            default: begin
                state_next = r2fft_pkg::ST_LOAD;
            end
        endcase
    end

    r2fft_ram #(
        .WIDTH(r2fft_pkg::ENTRY_W),
        .DEPTH(r2fft_pkg::MAX_POINTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    r2fft_bfly u_bfly (
        .aclk    (aclk),
        .ctrl    (bctrl),
        .rd_data (ram_rdata),
        .w_re    (w_re),
        .w_im    (w_im),
        .a_data  (a_data),
        .b_data  (b_data)
    );

    assign m_valid     = m_valid_reg;
    assign m_bin_real  = out_data_reg[r2fft_pkg::ENTRY_W-1:DW];
    assign m_bin_imag  = out_data_reg[DW-1:0];
    assign m_bin_index = out_index_reg;
    assign m_last_bin  = out_last_reg;

    // loading and emitting never overlap
    a_load_emit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready while a bin is pending");

    // the ram is never written while bins are read out
    a_no_write_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == r2fft_pkg::ST_EM_RD || state_reg == r2fft_pkg::ST_EM_LD ||
         state_reg == r2fft_pkg::ST_EM_OUT) |-> !ram_we)
        else $error("ram write during readout");

    // load count stays below the largest frame
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !load_count_reg[AW])
        else $error("load count out of range");

    // each bin transfer is followed by a gap while the next one is read
    a_bin_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> !m_valid)
        else $error("back to back bins from a single read port");

endmodule
